FILE: rtl/ara_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ara_pkg
// Types and constants shared by the address range allocator modules.
// ----------------------------------------------------------------------------
package ara_pkg;

	localparam int PNB = 36;       // page number bits
	localparam int CW  = PNB + 1;  // page count bits
	localparam int EW  = PNB + 2;  // range end / adder bits

	typedef logic [PNB-1:0] addr_t;
	typedef logic [CW-1:0]  cnt_t;
	typedef logic [EW-1:0]  wide_t;

	localparam logic [2:0] CMD_ADD_FREE = 3'd0;
	localparam logic [2:0] CMD_ADD_USED = 3'd1;
	localparam logic [2:0] CMD_ALLOC    = 3'd2;
	localparam logic [2:0] CMD_ALLOC_AT = 3'd3;
	localparam logic [2:0] CMD_FREE     = 3'd4;
	localparam logic [2:0] CMD_IS_FREE  = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OVERLAP = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_HANDLE  = 3'd4;

	localparam wide_t SPACE_END = wide_t'(1) << PNB;

	typedef struct packed {
		logic [2:0] cmd;
		addr_t      page_addr;
		cnt_t       page_len;
	} ara_req_t;

	typedef struct packed {
		logic [2:0] status;
		addr_t      result_addr;
		logic       region_free;
	} ara_rsp_t;

	typedef struct packed {
		addr_t start;
		cnt_t  pages;
		logic  used;
	} ent_t;

	typedef struct packed {
		logic  sub;
		wide_t x;
		wide_t z;
	} alu_op_t;

	function automatic wide_t wa(addr_t v);
		return {2'b00, v};
	endfunction

	function automatic wide_t wc(cnt_t v);
		return {1'b0, v};
	endfunction

endpackage

FILE: rtl/ara_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ara_alu
// Shared add/subtract unit used by the allocator sequencer.
// ----------------------------------------------------------------------------
module ara_alu (
	input  ara_pkg::alu_op_t op,
	output ara_pkg::wide_t   y
);
	import ara_pkg::*;

	assign y = op.sub ? (op.x - op.z) : (op.x + op.z);

endmodule

FILE: rtl/ara_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ara_table
// Range table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ara_table #(
	parameter int ENTRIES = 64,
	parameter int AW      = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ara_pkg::ent_t   wdata,
	input  logic [AW-1:0]   raddr,
	output ara_pkg::ent_t   rdata
);
	import ara_pkg::*;

	ent_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/address_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_allocator
// Best-fit page range allocator over an address-sorted table with coalescing.
//
//   channel   signals                 transfer
//   command   start, busy, req        start high while busy low
//   result    done, rsp               done high for one cycle
//
// A command walks the table entry by entry through the read port (S_RD, then
// S_EV), then moves entries one at a time (a read, then a write) to open or
// close a slot. All address and page-count add/subtract work goes through
// the one shared adder.
// Reset leaves the table empty; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the result cycle ends.
// ----------------------------------------------------------------------------
module address_range_allocator #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ara_pkg::ara_req_t req,
	output logic              done,
	output ara_pkg::ara_rsp_t rsp
);
	import ara_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int IW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IW:0] FULL_N = (IW+1)'(TABLE_ENTRIES);

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_CHK  = 12'b000000000010,
		S_RD   = 12'b000000000100,
		S_EV   = 12'b000000001000,
		S_P1   = 12'b000000010000,
		S_P2   = 12'b000000100000,
		S_WR   = 12'b000001000000,
		S_DRD  = 12'b000010000000,
		S_DWR  = 12'b000100000000,
		S_IRD  = 12'b001000000000,
		S_IWR  = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [IW-1:0] n_q, idx_q, pos_q, wr_idx_q, drop_pos_q, ins1_pos_q, ins2_pos_q;
	logic [2:0] cmd_q, status_q;
	addr_t a_q, res_q;
	cnt_t c_q;
	wide_t end_q, hit_e_q, prv_e_q;
	logic rfree_q, found_q, nxt_v_q, wr_v_q, ins1_v_q, ins2_v_q;
	ent_t hit_q, prv_q, nxt_q, wr_q, ins1_q, ins2_q;
	logic [1:0] drops_q;

	alu_op_t alu_op;
	wide_t alu_y;
	ent_t rd;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	ent_t mem_wdata;

	logic [IW-1:0] idx_nx, idx_pv;
	logic c_zero, n_full, need_over, at_lo, at_hi;
	logic prv_adj, nxt_adj, mp, mn, ev_fit;

	ara_alu u_alu (
		.op (alu_op),
		.y  (alu_y)
	);

	ara_table #(
		.ENTRIES (TABLE_ENTRIES),
		.AW      (AW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = '{status: status_q, result_addr: res_q, region_free: rfree_q};

	assign idx_nx    = idx_q + 1'b1;
	assign idx_pv    = idx_q - 1'b1;
	assign c_zero    = (c_q == '0);
	assign n_full    = ({1'b0, n_q} >= FULL_N);
	assign at_lo     = (hit_q.start < a_q);
	assign at_hi     = (end_q < hit_e_q);
	assign need_over = (({1'b0, n_q} + (IW+1)'(at_lo) + (IW+1)'(at_hi)) > FULL_N);
	assign prv_adj   = (pos_q != '0) && !prv_q.used && (prv_e_q == wa(a_q));
	assign nxt_adj   = nxt_v_q && !nxt_q.used &&
		(wa(nxt_q.start) == ((cmd_q == CMD_FREE) ? hit_e_q : end_q));
	// merges apply to free space only
	assign mp        = (cmd_q == CMD_ADD_USED) ? 1'b0 : prv_adj;
	assign mn        = (cmd_q == CMD_ADD_USED) ? 1'b0 : nxt_adj;
	assign ev_fit    = !rd.used && (wa(rd.start) <= wa(a_q)) && (end_q <= alu_y);

	// shared adder operand selection
	always_comb begin
		alu_op = '{sub: 1'b0, x: wa(rd.start), z: wc(rd.pages)};
		unique case (state_q)
			S_IDLE: alu_op = '{sub: 1'b0, x: wa(req.page_addr), z: wc(req.page_len)};
			S_P1: begin
				case (cmd_q) inside
					CMD_ADD_FREE, CMD_ADD_USED:
						alu_op = '{sub: 1'b0, x: wc(mp ? prv_q.pages : nxt_q.pages), z: wc(c_q)};
					CMD_ALLOC:
						alu_op = '{sub: 1'b0, x: wa(hit_q.start), z: wc(c_q)};
					CMD_ALLOC_AT:
						alu_op = '{sub: 1'b1, x: wa(a_q), z: wa(hit_q.start)};
					CMD_FREE:
						alu_op = '{sub: 1'b0, x: wc(prv_adj ? prv_q.pages : hit_q.pages),
							z: wc(prv_adj ? hit_q.pages : nxt_q.pages)};
					default: ;
				endcase
			end
			S_P2: begin
				case (cmd_q) inside
					CMD_ALLOC:    alu_op = '{sub: 1'b1, x: wc(hit_q.pages), z: wc(c_q)};
					CMD_ALLOC_AT: alu_op = '{sub: 1'b1, x: hit_e_q, z: end_q};
					default:      alu_op = '{sub: 1'b0, x: wc(wr_q.pages), z: wc(nxt_q.pages)};
				endcase
			end
			default: ;
		endcase
	end

	// table port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = rd;
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_DRD: mem_raddr = idx_nx[AW-1:0];
			S_IRD: begin
				mem_raddr = idx_pv[AW-1:0];
				if (idx_q <= ins1_pos_q) begin
					mem_we    = 1'b1;
					mem_wdata = ins1_q;
				end
			end
			S_WR: begin
				mem_we    = wr_v_q;
				mem_waddr = wr_idx_q[AW-1:0];
				mem_wdata = wr_q;
			end
			S_DWR, S_IWR: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			n_q        <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			wr_idx_q   <= '0;
			drop_pos_q <= '0;
			ins1_pos_q <= '0;
			ins2_pos_q <= '0;
			cmd_q      <= '0;
			status_q   <= ST_OK;
			a_q        <= '0;
			res_q      <= '0;
			c_q        <= '0;
			end_q      <= '0;
			hit_e_q    <= '0;
			prv_e_q    <= '0;
			rfree_q    <= 1'b0;
			found_q    <= 1'b0;
			nxt_v_q    <= 1'b0;
			wr_v_q     <= 1'b0;
			ins1_v_q   <= 1'b0;
			ins2_v_q   <= 1'b0;
			hit_q      <= '0;
			prv_q      <= '0;
			nxt_q      <= '0;
			wr_q       <= '0;
			ins1_q     <= '0;
			ins2_q     <= '0;
			drops_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= req.cmd;
						a_q      <= req.page_addr;
						c_q      <= req.page_len;
						end_q    <= alu_y;
						status_q <= ST_OK;
						res_q    <= '0;
						rfree_q  <= 1'b0;
						state_q  <= S_CHK;
					end
				end
				S_CHK: begin
					idx_q    <= '0;
					found_q  <= 1'b0;
					nxt_v_q  <= 1'b0;
					wr_v_q   <= 1'b0;
					drops_q  <= '0;
					ins1_v_q <= 1'b0;
					ins2_v_q <= 1'b0;
					state_q  <= S_RD;
					case (cmd_q) inside
						CMD_ADD_FREE, CMD_ADD_USED: begin
							if (c_zero) begin
								state_q <= S_DONE;
							end else if (end_q > SPACE_END) begin
								status_q <= ST_OVERLAP;
								state_q  <= S_DONE;
							end
						end
						CMD_ALLOC: begin
							if (c_zero) begin
								status_q <= ST_NOFIT;
								state_q  <= S_DONE;
							end
						end
						CMD_ALLOC_AT: begin
							if (c_zero || end_q > SPACE_END) begin
								status_q <= ST_NOFIT;
								state_q  <= S_DONE;
							end
						end
						CMD_FREE: ;
						CMD_IS_FREE: begin
							if (c_zero) begin
								state_q <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_RD: begin
					if (idx_q == n_q) begin
						if (cmd_q == CMD_IS_FREE) begin
							state_q <= S_DONE;
						end else begin
							if (cmd_q == CMD_ADD_FREE || cmd_q == CMD_ADD_USED) begin
								pos_q <= idx_q;
							end
							state_q <= S_P1;
						end
					end else begin
						state_q <= S_EV;
					end
				end
				S_EV: begin
					case (cmd_q) inside
						CMD_ADD_FREE, CMD_ADD_USED: begin
							if (wa(rd.start) < end_q && alu_y > wa(a_q)) begin
								status_q <= ST_OVERLAP;
								state_q  <= S_DONE;
							end else if (wa(rd.start) >= end_q) begin
								pos_q   <= idx_q;
								nxt_q   <= rd;
								nxt_v_q <= 1'b1;
								state_q <= S_P1;
							end else begin
								prv_q   <= rd;
								prv_e_q <= alu_y;
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						CMD_ALLOC: begin
							// first of the smallest fitting free ranges
							if (!rd.used && rd.pages >= c_q &&
								(!found_q || rd.pages < hit_q.pages)) begin
								found_q <= 1'b1;
								hit_q   <= rd;
								pos_q   <= idx_q;
							end
							idx_q   <= idx_nx;
							state_q <= S_RD;
						end
						CMD_ALLOC_AT: begin
							if (ev_fit) begin
								found_q <= 1'b1;
								hit_q   <= rd;
								hit_e_q <= alu_y;
								pos_q   <= idx_q;
								state_q <= S_P1;
							end else begin
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						CMD_FREE: begin
							if (found_q) begin
								nxt_q   <= rd;
								nxt_v_q <= 1'b1;
								state_q <= S_P1;
							end else if (rd.start == a_q && rd.used) begin
								found_q <= 1'b1;
								hit_q   <= rd;
								hit_e_q <= alu_y;
								pos_q   <= idx_q;
								if (idx_nx < n_q) begin
									idx_q   <= idx_nx;
									state_q <= S_RD;
								end else begin
									state_q <= S_P1;
								end
							end else begin
								prv_q   <= rd;
								prv_e_q <= alu_y;
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						CMD_IS_FREE: begin
							if (ev_fit) begin
								rfree_q <= 1'b1;
								state_q <= S_DONE;
							end else begin
								idx_q   <= idx_nx;
								state_q <= S_RD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_P1: begin
					state_q <= S_WR;
					case (cmd_q) inside
						CMD_ADD_FREE, CMD_ADD_USED: begin
							if (mp) begin
								wr_v_q   <= 1'b1;
								wr_idx_q <= pos_q - 1'b1;
								wr_q     <= '{start: prv_q.start, pages: alu_y[CW-1:0], used: 1'b0};
								if (mn) begin
									drops_q    <= 2'd1;
									drop_pos_q <= pos_q;
									state_q    <= S_P2;
								end
							end else if (mn) begin
								wr_v_q   <= 1'b1;
								wr_idx_q <= pos_q;
								wr_q     <= '{start: a_q, pages: alu_y[CW-1:0], used: 1'b0};
							end else if (n_full) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								ins1_v_q   <= 1'b1;
								ins1_pos_q <= pos_q;
								ins1_q     <= '{start: a_q, pages: c_q,
									used: (cmd_q == CMD_ADD_USED)};
							end
						end
						CMD_ALLOC: begin
							if (!found_q) begin
								status_q <= ST_NOFIT;
								state_q  <= S_DONE;
							end else if (hit_q.pages > c_q && n_full) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								res_q    <= hit_q.start;
								wr_v_q   <= 1'b1;
								wr_idx_q <= pos_q;
								wr_q     <= '{start: hit_q.start, pages: c_q, used: 1'b1};
								if (hit_q.pages > c_q) begin
									// remainder stays free just above
									ins1_v_q     <= 1'b1;
									ins1_pos_q   <= pos_q + 1'b1;
									ins1_q.start <= alu_y[PNB-1:0];
									ins1_q.used  <= 1'b0;
									state_q      <= S_P2;
								end
							end
						end
						CMD_ALLOC_AT: begin
							if (!found_q) begin
								status_q <= ST_NOFIT;
								state_q  <= S_DONE;
							end else if (need_over) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								res_q    <= a_q;
								wr_v_q   <= 1'b1;
								wr_idx_q <= pos_q;
								if (at_lo) begin
									wr_q       <= '{start: hit_q.start, pages: alu_y[CW-1:0],
										used: 1'b0};
									ins1_v_q   <= 1'b1;
									ins1_pos_q <= pos_q + 1'b1;
									ins1_q     <= '{start: a_q, pages: c_q, used: 1'b1};
									if (at_hi) begin
										ins2_v_q     <= 1'b1;
										ins2_pos_q   <= pos_q + 2'd2;
										ins2_q.start <= end_q[PNB-1:0];
										ins2_q.used  <= 1'b0;
										state_q      <= S_P2;
									end
								end else begin
									wr_q <= '{start: a_q, pages: c_q, used: 1'b1};
									if (at_hi) begin
										ins1_v_q     <= 1'b1;
										ins1_pos_q   <= pos_q + 1'b1;
										ins1_q.start <= end_q[PNB-1:0];
										ins1_q.used  <= 1'b0;
										state_q      <= S_P2;
									end
								end
							end
						end
						CMD_FREE: begin
							if (!found_q) begin
								status_q <= ST_HANDLE;
								state_q  <= S_DONE;
							end else begin
								wr_v_q <= 1'b1;
								if (prv_adj) begin
									wr_idx_q   <= pos_q - 1'b1;
									wr_q       <= '{start: prv_q.start, pages: alu_y[CW-1:0],
										used: 1'b0};
									drops_q    <= nxt_adj ? 2'd2 : 2'd1;
									drop_pos_q <= pos_q;
									if (nxt_adj) begin
										state_q <= S_P2;
									end
								end else if (nxt_adj) begin
									wr_idx_q   <= pos_q;
									wr_q       <= '{start: a_q, pages: alu_y[CW-1:0], used: 1'b0};
									drops_q    <= 2'd1;
									drop_pos_q <= pos_q + 1'b1;
								end else begin
									wr_idx_q <= pos_q;
									wr_q     <= '{start: a_q, pages: hit_q.pages, used: 1'b0};
								end
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_P2: begin
					state_q <= S_WR;
					case (cmd_q) inside
						CMD_ALLOC: ins1_q.pages <= alu_y[CW-1:0];
						CMD_ALLOC_AT: begin
							if (at_lo) begin
								ins2_q.pages <= alu_y[CW-1:0];
							end else begin
								ins1_q.pages <= alu_y[CW-1:0];
							end
						end
						default: wr_q.pages <= alu_y[CW-1:0];
					endcase
				end
				S_WR: begin
					if (drops_q != '0) begin
						idx_q   <= drop_pos_q;
						state_q <= S_DRD;
					end else if (ins1_v_q) begin
						idx_q   <= n_q;
						state_q <= S_IRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DRD: begin
					// pull the tail down one slot
					if (idx_nx < n_q) begin
						state_q <= S_DWR;
					end else begin
						n_q     <= n_q - 1'b1;
						drops_q <= drops_q - 1'b1;
						if (drops_q == 2'd2) begin
							idx_q <= drop_pos_q;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DWR: begin
					idx_q   <= idx_nx;
					state_q <= S_DRD;
				end
				S_IRD: begin
					// push the tail up one slot, then drop the new entry in
					if (idx_q > ins1_pos_q) begin
						state_q <= S_IWR;
					end else begin
						n_q <= n_q + 1'b1;
						if (ins2_v_q) begin
							ins1_q     <= ins2_q;
							ins1_pos_q <= ins2_pos_q;
							ins2_v_q   <= 1'b0;
							idx_q      <= n_q + 1'b1;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_IWR: begin
					idx_q   <= idx_pv;
					state_q <= S_IRD;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sim/address_range_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_allocator_tb
// Self-checking bench for the page range allocator. A directed opening covers
// empty-table errors, the top of the page space, every merge shape, a split
// on both sides and unknown commands. A random phase follows, in which some
// commands are aimed at ranges that exist. It includes one burst that fills
// the table and a later burst that frees those ranges again. A table model
// predicts each result.
// ----------------------------------------------------------------------------
module address_range_allocator_tb;
	import ara_pkg::*;

	localparam int          N_ENT      = 64;
	localparam int          N_RANDOM   = 575;
	localparam int          TAIL_ITEMS = 100;
	localparam int          DRAIN      = 500;
	localparam longint      LIMIT      = 2000000;
	localparam logic [63:0] TOP        = 64'd1 << PNB;
	localparam logic [63:0] FILL_BASE  = 64'd1 << 30;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ara_req_t req;
	logic     done;
	ara_rsp_t rsp;
	longint   cycles = 0;

	// table model and store of expected responses
	class alloc_scoreboard;
		logic [63:0] base[N_ENT];
		logic [63:0] len[N_ENT];
		logic        taken[N_ENT];
		int          count;
		ara_rsp_t    pending[$];
		int          mism;
		int          errors;
		int          seen;
		int          n_ok;
		int          n_full;

		function void insert_at(int pos, logic [63:0] s, logic [63:0] p, logic u);
			if (count >= N_ENT || pos > count) return;
			for (int i = count; i > pos; i--) begin
				base[i] = base[i-1]; len[i] = len[i-1]; taken[i] = taken[i-1];
			end
			base[pos] = s; len[pos] = p; taken[pos] = u;
			count++;
		endfunction

		function void remove_at(int pos);
			if (pos >= count) return;
			for (int i = pos; i + 1 < count; i++) begin
				base[i] = base[i+1]; len[i] = len[i+1]; taken[i] = taken[i+1];
			end
			count--;
		endfunction

		function logic [2:0] add_range(logic [63:0] a, logic [63:0] c, logic u);
			logic [63:0] e;
			int          pos;
			logic        mp, mn;
			e = a + c;
			if (c == 0) return ST_OK;
			if (e > TOP) return ST_OVERLAP;
			pos = count;
			for (int i = 0; i < count; i++) begin
				if (base[i] < e && base[i] + len[i] > a) return ST_OVERLAP;
				if (pos == count && base[i] >= e) pos = i;
			end
			mp = !u && pos > 0 && !taken[pos-1] && base[pos-1] + len[pos-1] == a;
			mn = !u && pos < count && !taken[pos] && base[pos] == e;
			if (mp && mn) begin
				len[pos-1] += c + len[pos];
				remove_at(pos);
			end else if (mp) begin
				len[pos-1] += c;
			end else if (mn) begin
				base[pos] = a;
				len[pos] += c;
			end else begin
				if (count >= N_ENT) return ST_FULL;
				insert_at(pos, a, c, u);
			end
			return ST_OK;
		endfunction

		function void note(ara_req_t r);
			logic [63:0] a, c, e, s, x;
			ara_rsp_t    o;
			int          best, need, i;
			logic        found;
			a = 64'(r.page_addr);
			c = 64'(r.page_len);
			e = a + c;
			o = '0;
			case (r.cmd)
				CMD_ADD_FREE: o.status = add_range(a, c, 1'b0);
				CMD_ADD_USED: o.status = add_range(a, c, 1'b1);
				CMD_ALLOC: begin
					found = 1'b0; best = 0;
					for (i = 0; i < count; i++) begin
						if (taken[i] || len[i] < c) continue;
						if (!found || len[i] < len[best]) begin
							found = 1'b1; best = i;
						end
					end
					if (c == 0 || !found) begin
						o.status = ST_NOFIT;
					end else if (len[best] > c && count >= N_ENT) begin
						o.status = ST_FULL;
					end else begin
						if (len[best] > c) insert_at(best + 1, base[best] + c, len[best] - c, 1'b0);
						len[best] = c;
						taken[best] = 1'b1;
						o.result_addr = addr_t'(base[best]);
					end
				end
				CMD_ALLOC_AT: begin
					o.status = ST_NOFIT;
					if (c != 0 && e <= TOP) begin
						for (i = 0; i < count; i++) begin
							s = base[i];
							x = s + len[i];
							if (taken[i] || s > a || e > x) continue;
							need = (s < a ? 1 : 0) + (e < x ? 1 : 0);
							if (count + need > N_ENT) begin
								o.status = ST_FULL;
								break;
							end
							if (e < x) insert_at(i + 1, e, x - e, 1'b0);
							if (s < a) begin
								insert_at(i, s, a - s, 1'b0);
								i++;
							end
							base[i] = a; len[i] = c; taken[i] = 1'b1;
							o.result_addr = addr_t'(a);
							o.status = ST_OK;
							break;
						end
					end
				end
				CMD_FREE: begin
					o.status = ST_HANDLE;
					for (i = 0; i < count; i++) begin
						if (base[i] != a || !taken[i]) continue;
						taken[i] = 1'b0;
						if (i > 0 && !taken[i-1] && base[i-1] + len[i-1] == base[i]) begin
							len[i-1] += len[i];
							remove_at(i);
							i--;
						end
						if (i + 1 < count && !taken[i+1] && base[i] + len[i] == base[i+1]) begin
							len[i] += len[i+1];
							remove_at(i + 1);
						end
						o.status = ST_OK;
						break;
					end
				end
				CMD_IS_FREE: begin
					if (c != 0)
						for (i = 0; i < count; i++)
							if (!taken[i] && base[i] <= a && e <= base[i] + len[i]) begin
								o.region_free = 1'b1;
								break;
							end
				end
				default: ;
			endcase
			if (o.status == ST_OK) n_ok++;
			if (o.status == ST_FULL) n_full++;
			pending.push_back(o);
		endfunction

		function void check(ara_rsp_t got);
			ara_rsp_t want;
			seen++;
			if (pending.size() == 0) begin
				errors++;
				if (mism++ < 10) $display("response with nothing pending: %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.result_addr !== want.result_addr ||
			    got.region_free !== want.region_free) begin
				errors++;
				if (mism++ < 10)
					$display("response %0d: expected status %0d addr %h free %b, got %0d %h %b",
					         seen, want.status, want.result_addr, want.region_free,
					         got.status, got.result_addr, got.region_free);
			end
		endfunction
	endclass

	alloc_scoreboard sb = new();

	address_range_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check(rsp);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("address_range_allocator_tb: errors");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send(logic [2:0] cmd, logic [63:0] a, logic [63:0] c, int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd       = cmd;
		req.page_addr = addr_t'(a);
		req.page_len  = cnt_t'(c);
		start         = 1'b1;
		while (busy) @(negedge clk);
		sb.note(req);
		@(negedge clk);
	endtask

	function automatic logic [63:0] wide_rand(int bits);
		return {$urandom, $urandom} & ((64'd1 << bits) - 1);
	endfunction

	// pick a command, biased toward ranges that the table holds
	task automatic random_item(int gap);
		logic [2:0]  cmd;
		logic [63:0] a, c;
		int          pick, k;
		pick = $urandom_range(0, 99);
		k    = (sb.count > 0) ? $urandom_range(0, sb.count - 1) : 0;
		a    = 64'($urandom_range(0, 4095));
		c    = 64'($urandom_range(1, 64));
		if (pick < 20) begin
			cmd = CMD_ADD_FREE;
		end else if (pick < 27) begin
			cmd = CMD_ADD_USED;
		end else if (pick < 45) begin
			cmd = CMD_ALLOC;
			c   = 64'($urandom_range(1, 40));
		end else if (pick < 57) begin
			cmd = CMD_ALLOC_AT;
			if (sb.count > 0 && $urandom_range(0, 3) != 0) begin
				a = sb.base[k] + 64'($urandom_range(0, 7));
				c = 64'($urandom_range(1, 16));
			end
		end else if (pick < 77) begin
			cmd = CMD_FREE;
			if (sb.count > 0 && $urandom_range(0, 4) != 0) a = sb.base[k];
		end else if (pick < 92) begin
			cmd = CMD_IS_FREE;
			if (sb.count > 0 && $urandom_range(0, 2) != 0) begin
				a = sb.base[k] + 64'($urandom_range(0, 3));
				c = 64'($urandom_range(0, 20));
			end
		end else if (pick < 95) begin
			cmd = 3'($urandom_range(6, 7));
			a   = wide_rand(PNB);
			c   = wide_rand(CW);
		end else begin
			// full-width fields, half the time near the top of the space
			cmd = 3'($urandom_range(0, 5));
			a   = wide_rand(PNB);
			c   = wide_rand(CW);
			if ($urandom_range(0, 1)) begin
				a = TOP - 64'($urandom_range(1, 300));
				c = 64'($urandom_range(0, 400));
			end
		end
		send(cmd, a, c, gap);
	endtask

	initial begin
		int gap;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed opening
		send(CMD_IS_FREE,  0, 1, 0);
		send(CMD_ALLOC,    0, 5, 0);
		send(CMD_FREE,     0, 0, 0);
		send(CMD_ADD_FREE, 0, 0, 0);
		send(CMD_ADD_FREE, TOP - 1, 2, 0);
		send(CMD_ADD_FREE, TOP - 8, 8, 1);
		send(CMD_IS_FREE,  TOP - 8, TOP, 0);
		send(CMD_ALLOC_AT, TOP - 4, 8, 0);
		send(CMD_ADD_FREE, 100, 50, 2);
		send(CMD_ADD_FREE, 150, 10, 0);   // joins the range below
		send(CMD_ADD_FREE, 90, 10, 0);    // joins the range above
		send(CMD_ADD_FREE, 170, 5, 0);
		send(CMD_ADD_FREE, 160, 10, 0);   // closes the hole, joins both
		send(CMD_ADD_USED, 200, 5, 3);
		send(CMD_ADD_FREE, 175, 25, 0);   // used neighbor above stays apart
		send(CMD_IS_FREE,  90, 110, 0);
		send(CMD_ALLOC,    0, 5, 0);
		send(CMD_ALLOC_AT, 100, 10, 0);   // free space left on both sides
		send(CMD_FREE,     100, 0, 0);
		send(CMD_ALLOC,    0, 0, 0);
		send(CMD_ALLOC_AT, 120, 0, 0);
		send(CMD_ADD_USED, 200, 1, 0);
		send(CMD_FREE,     205, 0, 0);
		send(3'd6, TOP - 1, (TOP << 1) - 1, 0);
		send(3'd7, 0, TOP, 0);

		for (int n = 0; n < N_RANDOM; n++) begin
			gap = (n < N_RANDOM - TAIL_ITEMS && $urandom_range(0, 3) == 0) ?
			      $urandom_range(1, 4) : 0;
			if (n == 250) begin
				// run the table into its limit
				for (int j = 0; j < 70; j++) send(CMD_ADD_USED, FILL_BASE + 2 * j, 1, 0);
				for (int j = 0; j < 10; j++) random_item(j % 3);
			end
			if (n == 400)
				for (int j = 0; j < 70; j++) send(CMD_FREE, FILL_BASE + 2 * j, 0, j % 2);
			random_item(gap);
		end
		start = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d responses checked, %0d ok, %0d table-full, table holds %0d ranges",
		         sb.seen, sb.n_ok, sb.n_full, sb.count);
		$display("%0d mismatches", sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("address_range_allocator_tb: clean");
		end else begin
			$display("address_range_allocator_tb: errors");
		end
		$finish;
	end

endmodule
